// File: rtl/disc_dma_register_controller_unit_assert.svh
// Assertion macros used by the disc DMA controller checker.
`ifndef DISC_DMA_REGISTER_CONTROLLER_UNIT_ASSERT_SVH
`define DISC_DMA_REGISTER_CONTROLLER_UNIT_ASSERT_SVH

// Checked only out of reset.
`define DDRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define DDRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/ddrc_pkg.sv
// Package for the disc DMA controller: widths, codes, register offsets, word types.
`default_nettype none

package ddrc_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SIZE_W   = 2;
  localparam int unsigned OFF_W    = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CADDR_W  = 29;
  localparam int unsigned CB_W     = 6;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned LEN_W    = 33;
  localparam int unsigned XCNT_W   = 27;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam int unsigned CHUNK_BYTES = 32;
  localparam int unsigned CHUNK_W     = $clog2(CHUNK_BYTES + 1);
  localparam int unsigned XFER_SHIFT  = 5;

  localparam logic [LEN_W-1:0]  ZERO_LEN_BYTES = LEN_W'(32 * 1024 * 1024);
  localparam logic [ID_W-1:0]   HW_ID_RESET    = 8'h94;
  localparam logic [DATA_W-1:0] CONST_FF       = 32'h0000_00ff;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [SIZE_W-1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2
  } size_e;

  typedef enum logic [OFF_W-1:0] {
    REG_START_ADDR = 8'h04,
    REG_LENGTH     = 8'h08,
    REG_ENABLE     = 8'h14,
    REG_START      = 8'h18,
    REG_SYS_MODE   = 8'hb0,
    REG_CONST      = 8'he4,
    REG_ADDR_CNT   = 8'hf4,
    REG_XFER_CNT   = 8'hf8
  } reg_e;

  typedef enum logic {
    CFG_HW_ID = 1'b0
  } cfg_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [SIZE_W-1:0] access_size;
    logic [OFF_W-1:0]  access_offset;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic               chunk_valid;
    logic [CADDR_W-1:0] chunk_address;
    logic [CB_W-1:0]    chunk_bytes;
    logic               dma_done;
  } rsp_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

`default_nettype wire

// File: rtl/ddrc_intf.sv
// Request and response channel interfaces of the disc DMA controller.
`default_nettype none

interface ddrc_req_if;
  import ddrc_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SIZE_W-1:0] access_size;
  logic [OFF_W-1:0]  access_offset;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, operation, access_size, access_offset, write_data,
                  input ready);
  modport sink   (input valid, operation, access_size, access_offset, write_data,
                  output ready);
endinterface

interface ddrc_rsp_if;
  import ddrc_pkg::*;
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_data;
  logic               chunk_valid;
  logic [CADDR_W-1:0] chunk_address;
  logic [CB_W-1:0]    chunk_bytes;
  logic               dma_done;

  modport source (output valid, read_data, chunk_valid, chunk_address, chunk_bytes,
                  dma_done, input ready);
  modport sink   (input valid, read_data, chunk_valid, chunk_address, chunk_bytes,
                  dma_done, output ready);
endinterface

`default_nettype wire

// File: rtl/ddrc_apb.sv
// APB configuration register holding the hardware ID byte.
`default_nettype none

module ddrc_apb (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel_i,
  input  wire logic                         penable_i,
  input  wire logic                         pwrite_i,
  input  wire logic [ddrc_pkg::APB_AW-1:0]  paddr_i,
  input  wire logic [ddrc_pkg::APB_DW-1:0]  pwdata_i,
  output logic      [ddrc_pkg::APB_DW-1:0]  prdata_o,
  output logic      [ddrc_pkg::ID_W-1:0]    hw_id_o
);
  import ddrc_pkg::*;

  logic [ID_W-1:0] hw_id_q, hw_id_d;
  logic            sel_id;

  assign sel_id = (paddr_i[APB_AW-1:2] == 1'(CFG_HW_ID));

  always_comb begin
    hw_id_d = hw_id_q;
    if (psel_i && penable_i && pwrite_i && sel_id) begin
      hw_id_d = pwdata_i[ID_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_id_q <= HW_ID_RESET;
    end else begin
      hw_id_q <= hw_id_d;
    end
  end

  assign prdata_o = sel_id ? APB_DW'(hw_id_q) : '0;
  assign hw_id_o  = hw_id_q;

endmodule

`default_nettype wire

// File: rtl/ddrc_in_stage.sv
// Input register of the request channel.
`default_nettype none

module ddrc_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  ddrc_req_if.sink             req_i,
  input  wire logic            advance_i,
  output ddrc_pkg::req_t       req_o,
  output logic                 valid_o
);
  import ddrc_pkg::*;

  logic valid_q, valid_d;
  req_t req_q;
  logic take;

  assign req_i.ready = !valid_q || advance_i;
  assign take        = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= '{operation:     req_i.operation,
                 access_size:   req_i.access_size,
                 access_offset: req_i.access_offset,
                 write_data:    req_i.write_data};
    end
  end

  assign req_o   = req_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// File: rtl/ddrc_core.sv
// Register file, start logic and chunk/tick engine of the disc DMA controller.
`default_nettype none

module ddrc_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  ddrc_pkg::stage_ctl_t            ctl_i,
  input  ddrc_pkg::req_t                  req_i,
  input  wire logic [ddrc_pkg::ID_W-1:0]  hw_id_i,
  output ddrc_pkg::rsp_t                  rsp_o
);
  import ddrc_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] start_addr;
    logic [DATA_W-1:0] length;
    logic [DATA_W-1:0] enable;
    logic              busy;
    logic [XCNT_W-1:0] xfer_cnt;
    logic [DATA_W-1:0] addr_cnt;
    logic [DATA_W-1:0] next_dest;
    logic [LEN_W-1:0]  bytes_left;
    logic [LEN_W-1:0]  latched_len;
    logic [LEN_W-1:0]  ticks_left;
  } state_t;

  state_t            st_q, st_d;
  rsp_t              rsp;
  logic [DATA_W-1:0] rd_word;
  logic [CHUNK_W-1:0] n;
  logic [LEN_W-1:0]  ticks_dec;
  logic [LEN_W-1:0]  start_len;

  always_comb begin
    unique case (req_i.access_offset)
      REG_ENABLE:   rd_word = st_q.enable;
      REG_START:    rd_word = DATA_W'(st_q.busy);
      REG_CONST:    rd_word = CONST_FF;
      REG_ADDR_CNT: rd_word = st_q.addr_cnt;
      REG_XFER_CNT: rd_word = DATA_W'(st_q.xfer_cnt);
      default:      rd_word = '0;
    endcase
  end

  assign n = (st_q.bytes_left < LEN_W'(CHUNK_BYTES)) ? CHUNK_W'(st_q.bytes_left)
                                                      : CHUNK_W'(CHUNK_BYTES);
  assign ticks_dec = st_q.ticks_left - LEN_W'(st_q.ticks_left != '0);
  assign start_len = (st_q.length == '0) ? ZERO_LEN_BYTES : LEN_W'(st_q.length);

  always_comb begin
    st_d = st_q;
    rsp  = '0;
    unique case (req_i.operation)
      OP_READ: begin
        if (req_i.access_size == SZ_BYTE) begin
          rsp.read_data = (req_i.access_offset == REG_SYS_MODE) ? DATA_W'(hw_id_i) : '0;
        end else if (req_i.access_size == SZ_WORD) begin
          rsp.read_data = rd_word;
        end
      end
      OP_WRITE: begin
        if (req_i.access_size == SZ_WORD) begin
          unique case (req_i.access_offset)
            REG_START_ADDR: st_d.start_addr = req_i.write_data;
            REG_LENGTH:     st_d.length     = req_i.write_data;
            REG_ENABLE:     st_d.enable     = req_i.write_data;
            REG_START: begin
              if (st_q.enable != '0 && req_i.write_data == DATA_W'(1) && !st_q.busy) begin
                st_d.busy        = 1'b1;
                st_d.xfer_cnt    = st_q.length[DATA_W-1:XFER_SHIFT];
                st_d.next_dest   = st_q.start_addr;
                st_d.latched_len = start_len;
                st_d.bytes_left  = start_len;
                st_d.ticks_left  = start_len;
              end
            end
            default: ;
          endcase
        end
      end
      OP_TICK: begin
        if (st_q.busy) begin
          if (st_q.bytes_left != '0) begin
            rsp.chunk_valid   = 1'b1;
            rsp.chunk_address = st_q.next_dest[CADDR_W-1:0];
            rsp.chunk_bytes   = CB_W'(n);
            st_d.bytes_left   = st_q.bytes_left - LEN_W'(n);
            st_d.next_dest    = st_q.next_dest + DATA_W'(n);
          end
          st_d.ticks_left = ticks_dec;
          if (ticks_dec == '0) begin
            st_d.addr_cnt   = st_q.addr_cnt + st_q.latched_len[DATA_W-1:0];
            st_d.xfer_cnt   = '0;
            st_d.busy       = 1'b0;
            st_d.bytes_left = '0;
            rsp.dma_done    = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (ctl_i.valid && ctl_i.advance) begin
      st_q <= st_d;
    end
  end

  assign rsp_o = rsp;

endmodule

`default_nettype wire

// File: rtl/ddrc_out_stage.sv
// Result register of the response channel.
`default_nettype none

module ddrc_out_stage (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  ddrc_pkg::rsp_t   rsp_i,
  output logic             advance_o,
  ddrc_rsp_if.source       rsp_o
);
  import ddrc_pkg::*;

  logic valid_q, valid_d;
  rsp_t rsp_q;

  assign advance_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign rsp_o.valid         = valid_q;
  assign rsp_o.read_data     = rsp_q.read_data;
  assign rsp_o.chunk_valid   = rsp_q.chunk_valid;
  assign rsp_o.chunk_address = rsp_q.chunk_address;
  assign rsp_o.chunk_bytes   = rsp_q.chunk_bytes;
  assign rsp_o.dma_done      = rsp_q.dma_done;

endmodule

`default_nettype wire

// File: rtl/disc_dma_register_controller_unit.sv
// Disc DMA register controller: top level.
//
// Request channel req_i carries one word per register read, register write or
// time tick; response channel rsp_o returns exactly one word for each, in order:
// read data, an optional chunk request (address, byte count) and the done pulse.
// The APB port holds the hardware ID byte returned by a byte read of the
// system mode register; write it only while no word is in flight.
// A word accepted into the input register passes the register/tick logic into
// the result register and is then presented on rsp_o. Throughput: one word per
// cycle while rsp_o.ready is high, set by the input register, the register/tick logic and the result register.
// Reset clears all DMA registers, counters and both stage valid flags; the ID
// byte returns to 0x94.
// When the receiver holds rsp_o.ready low, the result register holds its word,
// one more word waits in the input register, and then req_i.ready drops.
`default_nettype none

module disc_dma_register_controller_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  ddrc_req_if.sink                          req_i,
  ddrc_rsp_if.source                        rsp_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ddrc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [ddrc_pkg::APB_DW-1:0]  pwdata,
  output logic      [ddrc_pkg::APB_DW-1:0]  prdata,
  output logic                              pready
);
  import ddrc_pkg::*;

  req_t            s1_req;
  logic            s1_valid;
  logic            advance;
  rsp_t            s1_rsp;
  logic [ID_W-1:0] hw_id;
  stage_ctl_t      ctl;

  assign pready = 1'b1;
  assign ctl    = '{valid: s1_valid, advance: advance};

  ddrc_apb u_apb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .hw_id_o   (hw_id)
  );

  ddrc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .advance_i (advance),
    .req_o     (s1_req),
    .valid_o   (s1_valid)
  );

  ddrc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .req_i   (s1_req),
    .hw_id_i (hw_id),
    .rsp_o   (s1_rsp)
  );

  ddrc_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid),
    .rsp_i     (s1_rsp),
    .advance_o (advance),
    .rsp_o     (rsp_o)
  );

endmodule

`default_nettype wire

// File: rtl/ddrc_checker.sv
// Port-level checker for the disc DMA controller and its bind.
`default_nettype none

`include "disc_dma_register_controller_unit_assert.svh"

module ddrc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [ddrc_pkg::DATA_W-1:0]   read_data,
  input wire logic                          chunk_valid,
  input wire logic [ddrc_pkg::CADDR_W-1:0]  chunk_address,
  input wire logic [ddrc_pkg::CB_W-1:0]     chunk_bytes,
  input wire logic                          dma_done,
  input wire logic                          pready
);
  import ddrc_pkg::*;

  `DDRC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
  `DDRC_ASSERT(a_no_chunk_zero, rsp_valid && !chunk_valid |-> chunk_address == '0 && chunk_bytes == '0, "chunk fields set without chunk")
  `DDRC_ASSERT(a_tick_no_data, rsp_valid && (chunk_valid || dma_done) |-> read_data == '0, "tick word carries read data")
  `DDRC_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !rsp_valid, "response valid in reset")
  `DDRC_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind disc_dma_register_controller_unit ddrc_checker u_ddrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid     (rsp_o.valid),
  .rsp_ready     (rsp_o.ready),
  .read_data     (rsp_o.read_data),
  .chunk_valid   (rsp_o.chunk_valid),
  .chunk_address (rsp_o.chunk_address),
  .chunk_bytes   (rsp_o.chunk_bytes),
  .dma_done      (rsp_o.dma_done),
  .pready        (pready)
);

`default_nettype wire
